>>> design/cse_pkg.sv
// Shared types, constants and saturation helper for the Chebyshev series evaluator.
`timescale 1ns / 1ps

package cse_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned TERMS_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_HALF_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TERMS      = 2'd3;

    localparam logic signed [QW-1:0] RANGE_LOW_RST  = -32'sd65536;
    localparam logic signed [QW-1:0] RANGE_HIGH_RST = 32'sd65536;
    localparam logic signed [QW-1:0] INV_HW_RST     = 32'sd65536;
    localparam logic [TERMS_W-1:0]   NUM_TERMS_RST  = 6'd32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_YMUL,
        ST_YSCALE,
        ST_MUL,
        ST_ACC,
        ST_FMUL,
        ST_FACC
    } state_t;

    function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
        logic signed [QW-1:0] r;
        if (v > Q_MAX)
            r = Q_MAX[QW-1:0];
        else if (v < Q_MIN)
            r = Q_MIN[QW-1:0];
        else
            r = v[QW-1:0];
        return r;
    endfunction

endpackage

>>> design/chebyshev_series_eval.sv
// Top level: Chebyshev series evaluation by Clenshaw recurrence, Q16.16.
//
//   channel  signals                          direction  carries
//   s        s_tvalid s_tready s_tdata s_tuser in         load / evaluate items
//   m        m_tvalid m_tready m_tdata m_tuser out        series results
//   cfg      cfg_valid cfg_ready cfg_index cfg_data in    register writes
//
// A load item leaves s_tready high. An evaluate item steps through m terms, m the
// effective term count: one shared 32x32 multiplier, registered, feeds one
// saturating accumulate per term, on the coefficient RAM read.
// Reset restores the registers; table entries hold garbage until loaded.
// A full result register holds the last step until m_tready frees it.
`timescale 1ns / 1ps

module chebyshev_series_eval #(
    parameter int unsigned MAX_TERMS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [71:0]                     s_tdata,   // coef_index, coef_value, x_value, zero pad
    input  logic                            s_tuser,   // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // series_value
    output logic                            m_tuser,   // out_of_range
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int unsigned TW = (IW + 1 > cse_pkg::TERMS_W) ? IW + 1 : cse_pkg::TERMS_W;
    localparam int unsigned CW = ((IW > 5) ? IW : 5) + 1;
    localparam logic [TW-1:0] MAX_T = TW'(MAX_TERMS);

    logic signed [31:0] range_low_reg, range_high_reg, inv_hw_reg;
    logic [cse_pkg::TERMS_W-1:0] num_terms_reg;

    cse_pkg::state_t state_reg, state_next;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] diff_reg, diff_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] y2_reg, y2_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [31:0] dd_reg, dd_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [IW-1:0]      j_reg, j_next;
    logic               outside_reg, outside_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_flag_reg, out_flag_next;

    logic [4:0]         in_index;
    logic signed [31:0] in_coef, in_x;
    logic               in_accept;
    logic [CW-1:0]      slot_wide;
    logic               wr_en;
    logic signed [31:0] coef_rd;

    logic signed [32:0] mid_sum;
    logic signed [31:0] mid;
    logic [TW-1:0]      terms_ext;
    logic [IW-1:0]      last_j;
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] qm;
    logic signed [31:0] step_val, final_val;

    assign in_index  = s_tdata[4:0];
    assign in_coef   = s_tdata[36:5];
    assign in_x      = s_tdata[68:37];
    assign s_tready  = (state_reg == cse_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_wide = CW'(in_index);
    assign wr_en     = in_accept && (s_tuser == cse_pkg::CMD_LOAD)
                       && (slot_wide < CW'(MAX_TERMS));

    cse_coef_ram #(
        .DEPTH (MAX_TERMS),
        .AW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_wide[IW-1:0]),
        .wr_data (in_coef),
        .rd_addr (j_reg),
        .rd_data (coef_rd)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= cse_pkg::RANGE_LOW_RST;
            range_high_reg <= cse_pkg::RANGE_HIGH_RST;
            inv_hw_reg     <= cse_pkg::INV_HW_RST;
            num_terms_reg  <= cse_pkg::NUM_TERMS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cse_pkg::CFG_RANGE_LOW:      range_low_reg  <= cfg_data;
                cse_pkg::CFG_RANGE_HIGH:     range_high_reg <= cfg_data;
                cse_pkg::CFG_INV_HALF_WIDTH: inv_hw_reg     <= cfg_data;
                cse_pkg::CFG_NUM_TERMS:      num_terms_reg  <= cfg_data[cse_pkg::TERMS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective last term index: m clamped to [1, MAX_TERMS], minus one
    assign terms_ext = TW'(num_terms_reg);
    always_comb
    begin
        if (terms_ext <= TW'(1))
            last_j = '0;
        else if (terms_ext > MAX_T)
            last_j = IW'(MAX_TERMS - 1);
        else
            last_j = IW'(terms_ext - TW'(1));
    end

    assign mid_sum = 33'(range_low_reg) + 33'(range_high_reg);
    assign mid     = mid_sum[32:1];

    always_comb
    begin
        case (state_reg)
            cse_pkg::ST_YMUL:
            begin
                mul_a = diff_reg;
                mul_b = inv_hw_reg;
            end
            cse_pkg::ST_MUL:
            begin
                mul_a = y2_reg;
                mul_b = d_reg;
            end
            default:
            begin
                mul_a = y_reg;
                mul_b = d_reg;
            end
        endcase
    end

    assign qm        = cse_pkg::sat32(prod_reg >>> 16);
    assign step_val  = cse_pkg::sat32(64'(qm) - 64'(dd_reg) + 64'(coef_rd));
    assign final_val = cse_pkg::sat32(64'(qm) - 64'(dd_reg) + 64'(coef_rd >>> 1));

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        diff_next      = diff_reg;
        y_next         = y_reg;
        y2_next        = y2_reg;
        d_next         = d_reg;
        dd_next        = dd_reg;
        prod_next      = prod_reg;
        j_next         = j_reg;
        outside_next   = outside_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_flag_next  = out_flag_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cse_pkg::ST_IDLE:
            begin
                if (in_accept && (s_tuser == cse_pkg::CMD_EVAL))
                begin
                    x_next     = in_x;
                    state_next = cse_pkg::ST_DIFF;
                end
            end
            cse_pkg::ST_DIFF:
            begin
                diff_next = cse_pkg::sat32(64'(x_reg) - 64'(mid));
                if (range_low_reg <= range_high_reg)
                    outside_next = (x_reg < range_low_reg) || (x_reg > range_high_reg);
                else
                    outside_next = (x_reg < range_high_reg) || (x_reg > range_low_reg);
                j_next     = last_j;
                state_next = cse_pkg::ST_YMUL;
            end
            cse_pkg::ST_YMUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = cse_pkg::ST_YSCALE;
            end
            cse_pkg::ST_YSCALE:
            begin
                y_next  = qm;
                y2_next = cse_pkg::sat32(64'(qm) + 64'(qm));
                d_next  = '0;
                dd_next = '0;
                if (j_reg != '0)
                    state_next = cse_pkg::ST_MUL;
                else
                    state_next = cse_pkg::ST_FMUL;
            end
            cse_pkg::ST_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = cse_pkg::ST_ACC;
            end
            cse_pkg::ST_ACC:
            begin
                dd_next = d_reg;
                d_next  = step_val;
                j_next  = j_reg - IW'(1);
                if (j_reg == IW'(1))
                    state_next = cse_pkg::ST_FMUL;
                else
                    state_next = cse_pkg::ST_MUL;
            end
            cse_pkg::ST_FMUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = cse_pkg::ST_FACC;
            end
            cse_pkg::ST_FACC:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = final_val;
                    out_flag_next  = outside_reg;
                    state_next     = cse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cse_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        diff_reg      <= diff_next;
        y_reg         <= y_next;
        y2_reg        <= y2_next;
        d_reg         <= d_next;
        dd_reg        <= dd_next;
        prod_reg      <= prod_next;
        outside_reg   <= outside_next;
        out_value_reg <= out_value_next;
        out_flag_reg  <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_flag_reg;

endmodule

>>> design/cse_coef_ram.sv
// Coefficient table: one write port, one registered read port.
`timescale 1ns / 1ps

module cse_coef_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic signed [cse_pkg::QW-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic signed [cse_pkg::QW-1:0] rd_data
);

    logic signed [cse_pkg::QW-1:0] mem [DEPTH];
    logic signed [cse_pkg::QW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
